### sv/lpht_pkg.sv
package lpht_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int OCC_W         = 10;
    localparam int KEY_W         = 32;
    localparam int HASH_W        = 32;
    localparam int VALUE_W       = 64;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;

    localparam logic [OCC_W-1:0] MAX_OCC_RESET = OCC_W'(768);

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET = 2'd0,
        REQ_SET = 2'd1,
        REQ_DEL = 2'd2
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_code_t;

    // One slot of the table as it sits in the slot memory.
    typedef struct packed {
        mark_t              mark;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_entry_t;

endpackage

### sv/lpht_intf.sv
interface lpht_req_if;
    import lpht_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key_id;
    logic [HASH_W-1:0]  key_hash;
    logic [VALUE_W-1:0] value_in;

    modport source (output valid, req_type, key_id, key_hash, value_in, input ready);
    modport sink (input valid, req_type, key_id, key_hash, value_in, output ready);
endinterface

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic                new_key;

    modport source (output valid, status, value_out, new_key, input ready);
    modport sink (input valid, status, value_out, new_key, output ready);
endinterface

interface lpht_cfg_if;
    import lpht_pkg::*;

    logic             valid;
    logic             ready;
    logic [OCC_W-1:0] max_occupancy;

    modport source (output valid, max_occupancy, input ready);
    modport sink (input valid, max_occupancy, output ready);
endinterface

### sv/lpht_slot_mem.sv
module lpht_slot_mem #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(SLOTS)-1:0]  waddr,
    input  lpht_pkg::slot_entry_t     wdata,
    input  logic [$clog2(SLOTS)-1:0]  raddr,
    output lpht_pkg::slot_entry_t     rdata
);
    import lpht_pkg::*;

    slot_entry_t slot_mem [SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
    end

    // Single read port, data registered.
    always_ff @(posedge clk)
    begin
        rdata_reg <= slot_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/lpht_ctrl.sv
module lpht_ctrl #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lpht_req_if.sink                      req,
    lpht_rsp_if.source                    rsp,
    input  logic [lpht_pkg::OCC_W-1:0]    max_occupancy,
    output logic                          mem_we,
    output logic [$clog2(SLOTS)-1:0]      mem_waddr,
    output lpht_pkg::slot_entry_t         mem_wdata,
    output logic [$clog2(SLOTS)-1:0]      mem_raddr,
    input  lpht_pkg::slot_entry_t         mem_rdata
);
    import lpht_pkg::*;

    localparam int AW   = $clog2(SLOTS);
    localparam int CW   = AW + 1;
    localparam int CMPW = (CW > OCC_W) ? CW : OCC_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       n_reg, n_next;
    logic                have_tomb_reg, have_tomb_next;
    logic [AW-1:0]       tomb_idx_reg, tomb_idx_next;
    logic [REQ_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CW-1:0]       used_reg, used_next;

    status_code_t        res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                res_newk_reg, res_newk_next;
    logic                wr_en_reg, wr_en_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    slot_entry_t         wr_entry_reg, wr_entry_next;
    logic                inc_reg, inc_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                out_newk_reg, out_newk_next;

    logic                is_empty, is_live, is_tomb, hit, last_slot, stop;
    logic                tomb_any, room, out_free;
    logic [AW-1:0]       tomb_at;

    // Decode of the slot read for the current probe position.
    always_comb
    begin
        is_empty  = (mem_rdata.mark == MARK_EMPTY);
        is_live   = (mem_rdata.mark == MARK_LIVE);
        is_tomb   = (mem_rdata.mark == MARK_TOMB);
        hit       = is_live && (mem_rdata.key == key_reg);
        last_slot = &n_reg;
        stop      = is_empty || hit || last_slot;
        tomb_any  = have_tomb_reg || is_tomb;
        tomb_at   = have_tomb_reg ? tomb_idx_reg : idx_reg;
        room      = CMPW'(used_reg) < CMPW'(max_occupancy);
        out_free  = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        have_tomb_next  = have_tomb_reg;
        tomb_idx_next   = tomb_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_newk_next   = res_newk_reg;
        wr_en_next      = wr_en_reg;
        wr_addr_next    = wr_addr_reg;
        wr_entry_next   = wr_entry_reg;
        inc_next        = inc_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_newk_next   = out_newk_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_entry_reg;
        mem_raddr = idx_reg + AW'(1);
        req.ready = (state_reg == S_IDLE);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                mem_raddr = req.key_hash[AW-1:0];
                if (req.valid)
                begin
                    op_next        = req.req_type;
                    key_next       = req.key_id;
                    val_next       = req.value_in;
                    idx_next       = req.key_hash[AW-1:0];
                    n_next         = '0;
                    have_tomb_next = 1'b0;
                    if (req.req_type != REQ_GET && req.req_type != REQ_SET &&
                        req.req_type != REQ_DEL)
                    begin
                        // Unknown request: answered without touching the table.
                        res_status_next = ST_MISS;
                        res_value_next  = '0;
                        res_newk_next   = 1'b0;
                        wr_en_next      = 1'b0;
                        inc_next        = 1'b0;
                        state_next      = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                if (!stop)
                begin
                    idx_next = idx_reg + AW'(1);
                    n_next   = n_reg + AW'(1);
                    if (is_tomb && !have_tomb_reg)
                    begin
                        have_tomb_next = 1'b1;
                        tomb_idx_next  = idx_reg;
                    end
                end
                else
                begin
                    state_next      = S_COMMIT;
                    res_status_next = ST_MISS;
                    res_value_next  = '0;
                    res_newk_next   = 1'b0;
                    wr_en_next      = 1'b0;
                    inc_next        = 1'b0;
                    wr_addr_next    = idx_reg;
                    wr_entry_next   = '{mark: MARK_LIVE, key: key_reg, value: val_reg};
                    case (op_reg)
                        REQ_GET:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                res_value_next  = mem_rdata.value;
                            end
                        end
                        REQ_DEL:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                wr_en_next      = 1'b1;
                                wr_entry_next   = '{mark: MARK_TOMB, key: mem_rdata.key,
                                                    value: mem_rdata.value};
                            end
                        end
                        REQ_SET:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                wr_en_next      = 1'b1;
                            end
                            else if (tomb_any)
                            begin
                                res_status_next = ST_OK;
                                res_newk_next   = 1'b1;
                                wr_en_next      = 1'b1;
                                wr_addr_next    = tomb_at;
                            end
                            else if (is_empty && room)
                            begin
                                res_status_next = ST_OK;
                                res_newk_next   = 1'b1;
                                wr_en_next      = 1'b1;
                                inc_next        = 1'b1;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    mem_we          = wr_en_reg;
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_newk_next   = res_newk_reg;
                    if (inc_reg)
                    begin
                        used_next = used_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            have_tomb_reg  <= 1'b0;
            tomb_idx_reg   <= '0;
            op_reg         <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            used_reg       <= '0;
            res_status_reg <= ST_MISS;
            res_value_reg  <= '0;
            res_newk_reg   <= 1'b0;
            wr_en_reg      <= 1'b0;
            wr_addr_reg    <= '0;
            wr_entry_reg   <= '{mark: MARK_EMPTY, key: '0, value: '0};
            inc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_value_reg  <= '0;
            out_newk_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            have_tomb_reg  <= have_tomb_next;
            tomb_idx_reg   <= tomb_idx_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            used_reg       <= used_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_newk_reg   <= res_newk_next;
            wr_en_reg      <= wr_en_next;
            wr_addr_reg    <= wr_addr_next;
            wr_entry_reg   <= wr_entry_next;
            inc_reg        <= inc_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_newk_reg   <= out_newk_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.new_key   = out_newk_reg;

endmodule

### sv/linear_probe_hash_table.sv
// Channel  Dir  Word contents                                Accepted when
// -------  ---  -------------------------------------------  -----------------------
// req      in   req_type, key_id, key_hash, value_in         req.valid && req.ready
// rsp      out  status, value_out, new_key                   rsp.valid && rsp.ready
// cfg      in   max_occupancy                                cfg.valid && cfg.ready
//
// A request word is taken, then the probe reads one slot per cycle through the
// single read port of the slot memory, and last any write-back is done and the
// result is loaded. An unknown request type skips the probe. After reset a
// clearing pass marks every slot empty; req.ready stays low during it, while
// cfg is always ready. A stalled rsp holds the finished result in the output
// register; the next request is taken meanwhile and waits only at its
// write-back.
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    lpht_req_if.sink    req,
    lpht_rsp_if.source  rsp,
    lpht_cfg_if.sink    cfg
);
    import lpht_pkg::*;

    localparam int AW = $clog2(SLOTS);

    // Occupancy limit; written only while the table is idle (unchecked user rule).
    logic [OCC_W-1:0] max_occ_reg, max_occ_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    slot_entry_t      mem_wdata;
    slot_entry_t      mem_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        max_occ_next = max_occ_reg;
        if (cfg.valid)
        begin
            max_occ_next = cfg.max_occupancy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_occ_reg <= MAX_OCC_RESET;
        end
        else
        begin
            max_occ_reg <= max_occ_next;
        end
    end

    // The probe sequencer walks the chain one slot per cycle and does at most
    // one write-back to the slot memory at the end of each request.
    lpht_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .max_occupancy (max_occ_reg),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // Mark, key and value of every slot live in one wide memory word.
    lpht_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### bench/tb_top.sv
module tb_top;
    import lpht_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;

    // The run is stopped when this many cycles pass without any word moving on
    // any channel. The longest quiet stretch of a correct run is the clearing
    // pass after reset, a full-table probe or the long output hold-off, so
    // this leaves a wide margin over each of them.
    localparam int unsigned QUIET_LIMIT = 20000;

    localparam int unsigned POOL_MAX = 64;

    // Request code that the block does not know.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    // One response word as the block should produce it.
    typedef struct packed {
        status_code_t       status;
        logic [VALUE_W-1:0] value_out;
        logic               new_key;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;

    lpht_req_if req_bus ();
    lpht_rsp_if rsp_bus ();
    lpht_cfg_if cfg_bus ();

    linear_probe_hash_table #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the table. Keys and values are only looked at for slots
    // that are marked live, so their start value does not matter.
    logic [KEY_W-1:0]   tbl_key   [SLOTS];
    logic [VALUE_W-1:0] tbl_value [SLOTS];
    mark_t              tbl_mark  [SLOTS];
    int unsigned        tbl_used;
    logic [OCC_W-1:0]   occ_limit;

    // Response words expected from the block, oldest first.
    rsp_word_t pending_rsp [$];

    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned rsp_hold_left = 0;

    // Key pool for the random traffic. Most requests reuse these keys with
    // their own hash so that gets and deletes find what earlier sets placed.
    logic [KEY_W-1:0]  pool_key  [POOL_MAX];
    logic [HASH_W-1:0] pool_hash [POOL_MAX];

    // Applies one request to the shadow table and returns the response word
    // it must cause. The probe starts at the masked hash and walks forward,
    // wrapping round, until it meets the key live or an empty slot, and it
    // gives up after one full turn. A set with no hit goes to the first
    // tombstone it passed; only when it would take an empty slot does the
    // occupancy limit apply. An unknown request type changes nothing and
    // reports a miss.
    function automatic rsp_word_t apply_request(input logic [REQ_W-1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [HASH_W-1:0] h,
                                                input logic [VALUE_W-1:0] v);
        rsp_word_t   r;
        int unsigned idx;
        int unsigned n;
        int unsigned hit_idx;
        int unsigned tomb_idx;
        int unsigned empty_idx;
        bit          hit;
        bit          have_tomb;
        bit          have_empty;
        bit          stop;

        r.status    = ST_MISS;
        r.value_out = '0;
        r.new_key   = 1'b0;
        hit         = 1'b0;
        have_tomb   = 1'b0;
        have_empty  = 1'b0;
        stop        = 1'b0;
        hit_idx     = 0;
        tomb_idx    = 0;
        empty_idx   = 0;

        if (op != REQ_GET && op != REQ_SET && op != REQ_DEL)
            return r;

        idx = h & (SLOTS - 1);
        for (n = 0; n < SLOTS && !stop; n++)
        begin
            if (tbl_mark[idx] == MARK_EMPTY)
            begin
                have_empty = 1'b1;
                empty_idx  = idx;
                stop       = 1'b1;
            end
            else if (tbl_mark[idx] == MARK_LIVE)
            begin
                if (tbl_key[idx] == k)
                begin
                    hit     = 1'b1;
                    hit_idx = idx;
                    stop    = 1'b1;
                end
            end
            else if (!have_tomb)
            begin
                have_tomb = 1'b1;
                tomb_idx  = idx;
            end
            if (!stop)
                idx = (idx + 1) & (SLOTS - 1);
        end

        case (op)
            REQ_GET:
            begin
                if (hit)
                begin
                    r.status    = ST_OK;
                    r.value_out = tbl_value[hit_idx];
                end
            end
            REQ_DEL:
            begin
                if (hit)
                begin
                    tbl_mark[hit_idx] = MARK_TOMB;
                    r.status          = ST_OK;
                end
            end
            default:
            begin
                if (hit)
                begin
                    tbl_value[hit_idx] = v;
                    r.status           = ST_OK;
                end
                else if (have_tomb)
                begin
                    tbl_key[tomb_idx]   = k;
                    tbl_value[tomb_idx] = v;
                    tbl_mark[tomb_idx]  = MARK_LIVE;
                    r.status            = ST_OK;
                    r.new_key           = 1'b1;
                end
                else if (have_empty && tbl_used + 1 <= occ_limit)
                begin
                    tbl_key[empty_idx]   = k;
                    tbl_value[empty_idx] = v;
                    tbl_mark[empty_idx]  = MARK_LIVE;
                    tbl_used++;
                    r.status             = ST_OK;
                    r.new_key            = 1'b1;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
        endcase
        return r;
    endfunction

    // Offers one request word, with random idle cycles ahead of it, and
    // records its expected response once the block takes it. The task is
    // entered and left at a falling edge; valid is left high on return so
    // that back-to-back words never see valid dropped and raised in one step.
    task automatic send_word(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [HASH_W-1:0] h, input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= op;
        req_bus.key_id   <= k;
        req_bus.key_hash <= h;
        req_bus.value_in <= v;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        pending_rsp.push_back(apply_request(op, k, h, v));
        @(negedge clk);
    endtask

    // Drops the request line and holds off until every expected response
    // word has come back.
    task automatic wait_drain();
        req_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Every request causes exactly one response, so once the queue is empty
    // the block is idle and the limit can be changed safely.
    task automatic write_limit(input logic [OCC_W-1:0] limit);
        wait_drain();
        cfg_bus.valid         <= 1'b1;
        cfg_bus.max_occupancy <= limit;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        occ_limit = limit;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // The receiver reads the stall rate at falling edges, so the rates are
    // changed at a rising edge to keep the two processes apart.
    task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
        @(posedge clk);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        @(negedge clk);
    endtask

    // Gets, deletes and an unknown request type on the freshly cleared table,
    // with most fields at their extremes.
    task automatic test_empty_table();
        send_word(REQ_GET, '1, '1, '1);
        send_word(REQ_DEL, 32'h0000_0001, '0, '0);
        send_word(REQ_UNKNOWN, '1, '1, '1);
        send_word(REQ_GET, '0, '0, '0);
    endtask

    // With a limit of one, the second new key is refused, while updating the
    // live key and reusing the tombstone it leaves stay allowed. Key zero is
    // an ordinary key, and an unknown request type must leave it alone.
    task automatic test_occupancy_limit();
        write_limit(OCC_W'(1));
        send_word(REQ_SET, 32'h1234_5678, 32'h0000_0000, '1);
        send_word(REQ_SET, 32'h0000_0000, 32'h0000_0000, 64'h0123_4567_89AB_CDEF);
        send_word(REQ_SET, 32'h1234_5678, 32'h0000_0000, '0);
        send_word(REQ_GET, 32'h1234_5678, 32'hFFFF_FC00, '1);
        send_word(REQ_DEL, 32'h1234_5678, 32'h0000_0000, '1);
        send_word(REQ_GET, 32'h1234_5678, 32'h0000_0000, '0);
        send_word(REQ_SET, 32'h0000_0000, 32'h0000_0000, '1);
        send_word(REQ_UNKNOWN, 32'h0000_0000, 32'h0000_0000, '0);
        send_word(REQ_GET, 32'h0000_0000, 32'h0000_0000, '0);
        send_word(REQ_SET, 32'hFFFF_FFFF, 32'h0000_0007, 64'h8000_0000_0000_0001);
    endtask

    // Keys whose hash starts at the last slot chain round to the front of the
    // table, past the live key in slot zero. Deleting one in the middle of
    // the chain must not cut off the keys behind it, and the next new key of
    // that chain takes the tombstone rather than the empty slot.
    task automatic test_wrap_and_tombstones();
        write_limit(OCC_W'(1023));
        send_word(REQ_SET, 32'hA000_0001, 32'hFFFF_FFFF, 64'h1111_1111_1111_1111);
        send_word(REQ_SET, 32'hA000_0002, 32'hFFFF_FFFF, 64'h2222_2222_2222_2222);
        send_word(REQ_SET, 32'hA000_0003, 32'hFFFF_FFFF, 64'h3333_3333_3333_3333);
        send_word(REQ_DEL, 32'hA000_0002, 32'hFFFF_FFFF, '1);
        send_word(REQ_GET, 32'hA000_0003, 32'hFFFF_FFFF, '0);
        send_word(REQ_SET, 32'hA000_0003, 32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210);
        send_word(REQ_SET, 32'hA000_0004, 32'hFFFF_FFFF, 64'h4444_4444_4444_4444);
        send_word(REQ_GET, 32'hA000_0004, 32'hFFFF_FFFF, '0);
        send_word(REQ_DEL, 32'hA000_0004, 32'hFFFF_FFFF, '0);
        send_word(REQ_DEL, 32'hA000_0004, 32'hFFFF_FFFF, '0);
        send_word(REQ_GET, 32'hA000_0003, 32'h0000_0005, '0);
    endtask

    // Fills the key pool. A third of the keys hash anywhere, a third crowd
    // into a four-slot window to build long chains, and the rest start at
    // the top slots so that their chains wrap.
    task automatic fill_pool(input int unsigned pool_n);
        int unsigned base;
        int unsigned j;
        logic [HASH_W-1:0] h;

        base = $urandom_range(SLOTS - 1);
        for (j = 0; j < pool_n; j++)
        begin
            pool_key[j] = $urandom;
            h = $urandom;
            case ($urandom_range(2))
                0: ;
                1: h = (h & ~(SLOTS - 1)) | ((base + $urandom_range(3)) & (SLOTS - 1));
                default: h = (h & ~(SLOTS - 1)) | (SLOTS - 1 - $urandom_range(2));
            endcase
            pool_hash[j] = h;
        end
    endtask

    // Random traffic under one limit and one idling pattern. Most words are
    // well-formed requests on pool keys; the rest are stray keys and pool keys
    // with the wrong hash, under random request codes that include unknown ones.
    task automatic test_random_traffic(input int unsigned n_items, input int unsigned pool_n,
                                       input logic [OCC_W-1:0] limit,
                                       input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned i;
        int unsigned j;
        int unsigned roll;
        int unsigned pick;
        logic [REQ_W-1:0]   op;
        logic [KEY_W-1:0]   k;
        logic [HASH_W-1:0]  h;
        logic [VALUE_W-1:0] v;

        write_limit(limit);
        set_idling(idle_pct, stall_pct);
        fill_pool(pool_n);
        for (i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(99);
            j    = $urandom_range(pool_n - 1);
            if (roll < 85)
            begin
                k    = pool_key[j];
                h    = pool_hash[j];
                pick = $urandom_range(99);
                if (pick < 40)
                    op = REQ_GET;
                else if (pick < 80)
                    op = REQ_SET;
                else
                    op = REQ_DEL;
            end
            else
            begin
                op = REQ_W'($urandom_range(3));
                k  = (roll < 95) ? $urandom : pool_key[j];
                h  = $urandom;
            end
            v = {$urandom, $urandom};
            send_word(op, k, h, v);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the block fills up and stops taking requests. Then
    // the sender waits until every response has come back.
    task automatic test_output_stall();
        int unsigned i;
        logic [KEY_W-1:0] k;

        wait_drain();
        set_idling(0, 0);
        @(posedge clk);
        rsp_hold_left = 400;
        @(negedge clk);
        for (i = 0; i < 24; i++)
        begin
            k = 32'h5000_0000 + (i % 6);
            send_word((i < 6) ? REQ_SET : ((i % 3 == 0) ? REQ_DEL : REQ_GET),
                      k, 32'h0000_0200 + (i % 6), {$urandom, $urandom});
        end
        wait_drain();
    endtask

    // Response side: a long hold-off when one is asked for, otherwise ready
    // drops at random with the current stall rate.
    always @(negedge clk)
    begin
        if (rsp_hold_left != 0)
        begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Each accepted response word is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_rsp
        rsp_word_t want;

        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.value_out !== want.value_out)
                begin
                    $error("value_out: expected %h, got %h", want.value_out,
                           rsp_bus.value_out);
                    fail_count++;
                end
                if (rsp_bus.new_key !== want.new_key)
                begin
                    $error("new_key: expected %b, got %b", want.new_key, rsp_bus.new_key);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: the run ends when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_key[s]   = '0;
            tbl_value[s] = '0;
            tbl_mark[s]  = MARK_EMPTY;
        end
        tbl_used  = 0;
        occ_limit = MAX_OCC_RESET;

        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = '0;
        req_bus.key_id        = '0;
        req_bus.key_hash      = '0;
        req_bus.value_in      = '0;
        rsp_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.max_occupancy = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // The block is still clearing its table here; the first request
        // simply waits until it is taken.
        test_empty_table();
        test_occupancy_limit();
        test_wrap_and_tombstones();

        // Random phases: the reset limit with no idling, then a limit just
        // above the current count so that sets are refused, then the highest
        // limit, then a low one with light idling on both channels.
        test_random_traffic(440, 64, MAX_OCC_RESET, 0, 0);
        test_random_traffic(440, 48, OCC_W'((tbl_used + 6 > 1023) ? 1023 : tbl_used + 6),
                            50, 0);
        test_output_stall();
        test_random_traffic(440, 64, OCC_W'(1023), 0, 50);
        test_random_traffic(440, 64, OCC_W'(200), 9, 9);

        wait_drain();
        repeat (SLOTS + 16) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
